// ===== design/ckvs_pkg.sv =====
// shared types, constants and the crc step for the checked key-value slot store
package ckvs_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'h504D5048;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [7:0]  REC_VERSION = 8'd1;
  localparam int          HDR_LEN     = 12;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_READY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_BAD_REQUEST  = 3'd3,
    ST_FULL         = 3'd4
  } status_e;

  typedef struct packed {
    logic    take;
    logic    scan_start;
    logic    slot_next;
    logic    slot_begin;
    logic    tgt_cur;
    logic    fetch_start;
    logic    fetch_word;
    logic    fetch_next;
    logic    wr_start;
    logic    clr_stg;
    logic    emit;
    logic    emit_data;
    logic    emit_final;
    status_e emit_code;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_store;
    logic req_last;
    logic scan_end;
    logic slot_written;
    logic slot_hit;
    logic have_inv;
    logic len_match;
    logic rd_busy;
    logic wr_busy;
    logic word_last;
    logic out_free;
  } sts_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== design/ckvs_ctrl.sv =====
// request sequencer: scan, fetch, write and result ordering
module ckvs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ckvs_pkg::sts_t  sts_i,
  output ckvs_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN_CHK, S_SCAN_RUN, S_SLOT_EVAL,
    S_LF_ISSUE, S_LF_WAIT, S_LF_EMIT, S_WR_WAIT, S_EMIT
  } state_e;

  state_e            state_q, state_d;
  ckvs_pkg::status_e em_q, em_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    em_d       = em_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts_i.req_bad) begin
          em_d    = ckvs_pkg::ST_BAD_REQUEST;
          state_d = S_EMIT;
        end else if (sts_i.req_store && !sts_i.req_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        priority if (sts_i.scan_end) begin
          priority if (!sts_i.req_store) begin
            em_d    = ckvs_pkg::ST_NOT_FOUND;
            state_d = S_EMIT;
          end else if (sts_i.have_inv) begin
            cmd_o.wr_start = 1'b1;
            state_d        = S_WR_WAIT;
          end else begin
            cmd_o.clr_stg = 1'b1;
            em_d          = ckvs_pkg::ST_FULL;
            state_d       = S_EMIT;
          end
        end else if (!sts_i.slot_written) begin
          cmd_o.slot_next = 1'b1;
        end else begin
          cmd_o.slot_begin = 1'b1;
          state_d          = S_SCAN_RUN;
        end
      end
      S_SCAN_RUN: begin
        if (!sts_i.rd_busy) state_d = S_SLOT_EVAL;
      end
      S_SLOT_EVAL: begin
        priority if (sts_i.slot_hit && !sts_i.req_store) begin
          if (sts_i.len_match) begin
            cmd_o.fetch_start = 1'b1;
            state_d           = S_LF_ISSUE;
          end else begin
            em_d    = ckvs_pkg::ST_LEN_MISMATCH;
            state_d = S_EMIT;
          end
        end else if (sts_i.slot_hit) begin
          cmd_o.tgt_cur  = 1'b1;
          cmd_o.wr_start = 1'b1;
          state_d        = S_WR_WAIT;
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d         = S_SCAN_CHK;
        end
      end
      S_LF_ISSUE: begin
        cmd_o.fetch_word = 1'b1;
        state_d          = S_LF_WAIT;
      end
      S_LF_WAIT: begin
        if (!sts_i.rd_busy) state_d = S_LF_EMIT;
      end
      S_LF_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_data  = 1'b1;
          cmd_o.emit_final = sts_i.word_last;
          cmd_o.emit_code  = ckvs_pkg::ST_OK;
          if (sts_i.word_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.fetch_next = 1'b1;
            state_d          = S_LF_ISSUE;
          end
        end
      end
      S_WR_WAIT: begin
        if (!sts_i.wr_busy) begin
          cmd_o.clr_stg = 1'b1;
          em_d          = ckvs_pkg::ST_OK;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_final = 1'b1;
          cmd_o.emit_code  = em_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      em_q    <= ckvs_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      em_q    <= em_d;
    end
  end

endmodule

// ===== design/ckvs_dp.sv =====
// datapath: slot memory, byte stream, crc, staging buffer, config and output register
module ckvs_dp #(
  parameter int MAX_SLOTS  = 32,
  parameter int SLOT_BYTES = 128,
  parameter int DATA_BYTES = 112
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [5:0]      cfg_data_i,
  input  logic            action_i,
  input  logic [31:0]     key_i,
  input  logic [6:0]      byte_count_i,
  input  logic [31:0]     data_word_i,
  input  logic            last_word_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [2:0]      status_o,
  output logic [31:0]     read_word_o,
  output logic [4:0]      word_index_o,
  output logic            final_result_o,
  input  ckvs_pkg::cmd_t  cmd_i,
  output ckvs_pkg::sts_t  sts_o
);

  localparam int DEPTH     = MAX_SLOTS * SLOT_BYTES;
  localparam int AW        = $clog2(DEPTH);
  localparam int SCAN_SPAN = DATA_BYTES + 16;
  localparam int WR_SPAN   = (SLOT_BYTES > SCAN_SPAN) ? SLOT_BYTES : SCAN_SPAN;
  localparam int OW        = $clog2(WR_SPAN + 1);
  localparam int SW        = $clog2(MAX_SLOTS + 1);
  localparam int SIW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int STG_WORDS = (DATA_BYTES + 3) / 4;
  localparam int SCW       = $clog2(STG_WORDS + 1);
  localparam int SIX       = (STG_WORDS > 1) ? $clog2(STG_WORDS) : 1;
  localparam int CRC_OFF   = ckvs_pkg::HDR_LEN + DATA_BYTES;

  // config
  logic [5:0] slots_q;
  logic       ready_q;
  logic [SW-1:0] n_slots;

  // request
  logic        store_q, last_q, bad_q;
  logic [31:0] key_q;
  logic [6:0]  len_q;
  logic        bad_in;

  // slot memory and write-once flags
  logic [7:0]           mem_q [DEPTH];
  logic [7:0]           mem_rd_q;
  logic [MAX_SLOTS-1:0] written_q;

  // scan state
  logic [SW-1:0]  slot_q;
  logic [SW-1:0]  tgt_q;
  logic           have_inv_q;
  logic [31:0]    magic_q, kcap_q, crc_st_q, crc_q;
  logic [15:0]    lcap_q;
  logic           cap_ok;
  logic           cur_written;

  // read stream
  logic           rd_run_q, rd_fetch_q, rd_vld_q, rd_in_q;
  logic [OW-1:0]  rd_off_q, rd_end_q, rd_tag_q;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_byte;
  logic [OW-1:0]  fpos;

  // fetch
  logic [4:0]     wi_q;
  logic [31:0]    fw_q;
  logic [5:0]     nw;

  // write sweep
  logic           wr_run_q;
  logic [OW-1:0]  wr_off_q;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_val, wr_eff;
  logic [OW-1:0]  wpos, wcrc;
  logic [OW-3:0]  wword;
  logic [31:0]    stg_word;

  // staging
  logic [31:0]    stg_q [STG_WORDS];
  logic [SCW-1:0] cnt_q;

  // output register
  logic           out_valid_q;
  logic [2:0]     status_q;
  logic [31:0]    word_q;
  logic [4:0]     idx_q;
  logic           final_q;

  assign n_slots = ({1'b0, slots_q} > 7'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(slots_q);
  assign bad_in  = !ready_q || (byte_count_i == 7'd0) || (32'(byte_count_i) > DATA_BYTES);

  assign cur_written = (slot_q < SW'(MAX_SLOTS)) && written_q[slot_q[SIW-1:0]];
  assign cap_ok      = (magic_q == ckvs_pkg::REC_MAGIC) && (32'(lcap_q) <= DATA_BYTES)
                     && (~crc_q == crc_st_q);

  assign rd_addr = AW'(slot_q) * AW'(SLOT_BYTES) + AW'(rd_off_q);
  assign rd_byte = rd_in_q ? mem_rd_q : 8'hFF;
  assign fpos    = rd_tag_q - OW'(ckvs_pkg::HDR_LEN);
  assign nw      = 6'((8'(len_q) + 8'd3) >> 2);

  // byte to be written at the current sweep offset
  assign wpos     = wr_off_q - OW'(ckvs_pkg::HDR_LEN);
  assign wcrc     = wr_off_q - OW'(CRC_OFF);
  assign wword    = wpos[OW-1:2];
  assign stg_word = (32'(wword) < 32'(cnt_q)) ? stg_q[wword[SIX-1:0]] : 32'd0;
  assign wr_addr  = AW'(tgt_q) * AW'(SLOT_BYTES) + AW'(wr_off_q);

  always_comb begin
    wr_val = 8'd0;
    priority if (wr_off_q < OW'(4)) begin
      wr_val = 8'(ckvs_pkg::REC_MAGIC >> (8 * wr_off_q[1:0]));
    end else if (wr_off_q < OW'(8)) begin
      wr_val = 8'(key_q >> (8 * wr_off_q[1:0]));
    end else if (wr_off_q == OW'(8)) begin
      wr_val = ckvs_pkg::REC_VERSION;
    end else if (wr_off_q == OW'(10)) begin
      wr_val = {1'b0, len_q};
    end else if (wr_off_q < OW'(ckvs_pkg::HDR_LEN)) begin
      wr_val = 8'd0;
    end else if (32'(wpos) < 32'(len_q)) begin
      wr_val = 8'(stg_word >> (8 * wpos[1:0]));
    end else if ((32'(wr_off_q) >= CRC_OFF) && (32'(wr_off_q) < CRC_OFF + 4)) begin
      wr_val = 8'((~crc_q) >> (8 * wcrc[1:0]));
    end else begin
      wr_val = 8'd0;
    end
  end
  assign wr_eff = (32'(wr_off_q) < SLOT_BYTES) ? wr_val : 8'hFF;

  // memory
  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[rd_addr];
    if (wr_run_q && (32'(wr_off_q) < SLOT_BYTES)) begin
      mem_q[wr_addr] <= wr_val;
    end
  end

  // staging words
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && action_i && !bad_in && (32'(cnt_q) < STG_WORDS)) begin
      stg_q[cnt_q[SIX-1:0]] <= data_word_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      key_q   <= key_i;
      len_q   <= byte_count_i;
    end
    if (cmd_i.slot_begin) begin
      crc_q <= ckvs_pkg::CRC_INIT;
    end else if (cmd_i.wr_start) begin
      crc_q <= ckvs_pkg::CRC_INIT;
    end else if (rd_vld_q && !rd_fetch_q) begin
      if ((32'(rd_tag_q) < ckvs_pkg::HDR_LEN)
          || (32'(rd_tag_q) < ckvs_pkg::HDR_LEN + 32'(lcap_q))) begin
        crc_q <= ckvs_pkg::crc_byte(crc_q, rd_byte);
      end
    end else if (wr_run_q && (32'(wr_off_q) < ckvs_pkg::HDR_LEN + 32'(len_q))) begin
      crc_q <= ckvs_pkg::crc_byte(crc_q, wr_eff);
    end
    if (rd_vld_q && !rd_fetch_q) begin
      if (rd_tag_q < OW'(4))                         magic_q  <= {rd_byte, magic_q[31:8]};
      else if (rd_tag_q < OW'(8))                    kcap_q   <= {rd_byte, kcap_q[31:8]};
      else if (rd_tag_q == OW'(10) || rd_tag_q == OW'(11)) lcap_q <= {rd_byte, lcap_q[15:8]};
      if ((32'(rd_tag_q) >= CRC_OFF) && (32'(rd_tag_q) < CRC_OFF + 4)) begin
        crc_st_q <= {rd_byte, crc_st_q[31:8]};
      end
    end
    if (cmd_i.fetch_word) begin
      fw_q <= 32'd0;
    end else if (rd_vld_q && rd_fetch_q) begin
      fw_q[8*fpos[1:0] +: 8] <= (32'(fpos) < 32'(len_q)) ? rd_byte : 8'd0;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_code;
      word_q   <= cmd_i.emit_data ? fw_q : 32'd0;
      idx_q    <= cmd_i.emit_data ? wi_q : 5'd0;
      final_q  <= cmd_i.emit_final;
    end
    rd_tag_q <= rd_off_q;
    rd_in_q  <= (32'(rd_off_q) < SLOT_BYTES);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= 6'd32;
      ready_q     <= 1'b0;
      store_q     <= 1'b0;
      last_q      <= 1'b0;
      bad_q       <= 1'b0;
      written_q   <= '0;
      slot_q      <= '0;
      tgt_q       <= '0;
      have_inv_q  <= 1'b0;
      rd_run_q    <= 1'b0;
      rd_fetch_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_off_q    <= '0;
      rd_end_q    <= '0;
      wi_q        <= '0;
      wr_run_q    <= 1'b0;
      wr_off_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ckvs_pkg::CFG_SLOTS: slots_q <= cfg_data_i;
          ckvs_pkg::CFG_READY: ready_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        store_q <= action_i;
        last_q  <= last_word_i;
        bad_q   <= bad_in;
        if (action_i) begin
          if (bad_in) cnt_q <= '0;
          else if (32'(cnt_q) < STG_WORDS) cnt_q <= cnt_q + SCW'(1);
        end
      end else if (cmd_i.clr_stg) begin
        cnt_q <= '0;
      end
      if (cmd_i.scan_start) begin
        slot_q     <= '0;
        have_inv_q <= 1'b0;
      end else if (cmd_i.slot_next) begin
        if (!(cur_written && cap_ok) && !have_inv_q) begin
          have_inv_q <= 1'b1;
          tgt_q      <= slot_q;
        end
        slot_q <= slot_q + SW'(1);
      end
      if (cmd_i.tgt_cur) tgt_q <= slot_q;
      // byte read stream, data lands in the cycle after its address
      rd_vld_q <= rd_run_q;
      if (cmd_i.slot_begin) begin
        rd_run_q   <= 1'b1;
        rd_fetch_q <= 1'b0;
        rd_off_q   <= '0;
        rd_end_q   <= OW'(SCAN_SPAN);
      end else if (cmd_i.fetch_word) begin
        rd_run_q   <= 1'b1;
        rd_fetch_q <= 1'b1;
        rd_off_q   <= OW'(ckvs_pkg::HDR_LEN) + OW'({wi_q, 2'b00});
        rd_end_q   <= OW'(ckvs_pkg::HDR_LEN) + OW'({wi_q, 2'b00}) + OW'(4);
      end else if (rd_run_q) begin
        rd_off_q <= rd_off_q + OW'(1);
        if (rd_off_q + OW'(1) == rd_end_q) rd_run_q <= 1'b0;
      end
      if (cmd_i.fetch_start)     wi_q <= '0;
      else if (cmd_i.fetch_next) wi_q <= wi_q + 5'd1;
      // slot rewrite sweep
      if (cmd_i.wr_start) begin
        wr_run_q <= 1'b1;
        wr_off_q <= '0;
      end else if (wr_run_q) begin
        wr_off_q <= wr_off_q + OW'(1);
        if (wr_off_q == OW'(WR_SPAN - 1)) begin
          wr_run_q                  <= 1'b0;
          written_q[tgt_q[SIW-1:0]] <= 1'b1;
        end
      end
      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.req_bad      = bad_q;
    sts_o.req_store    = store_q;
    sts_o.req_last     = last_q;
    sts_o.scan_end     = (slot_q >= n_slots);
    sts_o.slot_written = cur_written;
    sts_o.slot_hit     = cur_written && cap_ok && (kcap_q == key_q);
    sts_o.have_inv     = have_inv_q;
    sts_o.len_match    = (lcap_q == 16'(len_q));
    sts_o.rd_busy      = rd_run_q || rd_vld_q;
    sts_o.wr_busy      = wr_run_q;
    sts_o.word_last    = ((6'(wi_q) + 6'd1) == nw);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign read_word_o    = word_q;
  assign word_index_o   = idx_q;
  assign final_result_o = final_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an untaken word");
  a_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_run_q && rd_run_q))
    else $error("read stream and slot rewrite overlap");
  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_run_q |-> (tgt_q < SW'(MAX_SLOTS)))
    else $error("rewrite target out of range");
  a_wr_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_run_q && !cmd_i.wr_start && wr_off_q == OW'(WR_SPAN - 1)) |=> !wr_run_q)
    else $error("rewrite sweep overran its span");

endmodule

// ===== design/crc_checked_key_value_slot_store_unit.sv =====
// top level of the crc-checked key-value slot store
// a load scans slots in order up to the one holding its key, skipping never-written slots and
//   reading DATA_BYTES+16 bytes of each written one, then fetches each returned data word;
//   a store word before the last is only staged; a last store word scans slots up to the one
//   holding its key, then rewrites that slot (or the first invalid one) over max(SLOT_BYTES,
//   DATA_BYTES+16) byte offsets; one request at a time; reset: slots read as erased through
//   per-slot written flags, staging empty, slots_in_use 32, store_ready 0; no clearing pass
module crc_checked_key_value_slot_store_unit #(
  parameter int MAX_SLOTS  = 32,
  parameter int SLOT_BYTES = 128,
  parameter int DATA_BYTES = 112
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  // request words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] key_i,
  input  logic [6:0]  byte_count_i,
  input  logic [31:0] data_word_i,
  input  logic        last_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] read_word_o,
  output logic [4:0]  word_index_o,
  output logic        final_result_o
);

  // command and status between sequencer and datapath
  ckvs_pkg::cmd_t cmd;
  ckvs_pkg::sts_t sts;

  // sequencer: takes one request word, walks scan / fetch / rewrite
  ckvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: slot memory, crc check, staging and the result register
  ckvs_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .DATA_BYTES (DATA_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .key_i          (key_i),
    .byte_count_i   (byte_count_i),
    .data_word_i    (data_word_i),
    .last_word_i    (last_word_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .read_word_o    (read_word_o),
    .word_index_o   (word_index_o),
    .final_result_o (final_result_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
